@@ rtl/integer_partition_count_macros.svh @@
// ----------------------------------------------------------------------------
// integer_partition_count_macros.svh
// Assertion macros shared by the partition counter RTL.
// ----------------------------------------------------------------------------
`ifndef INTEGER_PARTITION_COUNT_MACROS_SVH
`define INTEGER_PARTITION_COUNT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define IPC_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ipc assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define IPC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ipc assertion failed");

`endif

@@ rtl/ipc_pkg.sv @@
// ----------------------------------------------------------------------------
// ipc_pkg
// Shared widths, types and defaults for the partition counter.
// ----------------------------------------------------------------------------
package ipc_pkg;

    localparam int NUM_W           = 7;
    localparam int COUNT_W         = 32;
    localparam int MAX_ENTRIES_DEF = 128;

    typedef logic [NUM_W-1:0]   num_t;
    typedef logic [COUNT_W-1:0] count_t;

endpackage

@@ rtl/ipc_channels.sv @@
// ----------------------------------------------------------------------------
// ipc_channels
// Valid/ready channels for requests and results of the partition counter.
// ----------------------------------------------------------------------------
interface ipc_req_if;
    import ipc_pkg::*;

    logic valid;
    logic ready;
    num_t number_in;

    modport source (output valid, output number_in, input ready);
    modport sink   (input valid, input number_in, output ready);
endinterface

interface ipc_rsp_if;
    import ipc_pkg::*;

    logic   valid;
    logic   ready;
    count_t partition_count;

    modport source (output valid, output partition_count, input ready);
    modport sink   (input valid, input partition_count, output ready);
endinterface

@@ rtl/ipc_table_ram.sv @@
// ----------------------------------------------------------------------------
// ipc_table_ram
// Count table: one write port, two read ports, registered read data.
// ----------------------------------------------------------------------------
module ipc_table_ram #(
    parameter int DEPTH = ipc_pkg::MAX_ENTRIES_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                clk,
    input  logic                wr_en,
    input  logic [AW-1:0]       wr_addr,
    input  ipc_pkg::count_t     wr_data,
    input  logic [AW-1:0]       rd_addr_a,
    input  logic [AW-1:0]       rd_addr_b,
    output ipc_pkg::count_t     rd_data_a,
    output ipc_pkg::count_t     rd_data_b
);
    import ipc_pkg::*;

    count_t mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // read-before-write: a same-address read returns the old word
    always_ff @(posedge clk)
    begin
        rd_data_a <= mem[rd_addr_a];
        rd_data_b <= mem[rd_addr_b];
    end

endmodule

@@ rtl/integer_partition_count.sv @@
// ----------------------------------------------------------------------------
// integer_partition_count
// Partition number p(n) by a one-dimensional count table rebuilt per request.
// ----------------------------------------------------------------------------
// One request transaction carries n; one result transaction returns p(n), the
// number of ways to write n as a sum of positive parts, order ignored. n = 0,
// and any n that does not fit the table (n >= MAX_ENTRIES), answer 0. The
// block handles one request at a time and holds request.ready low from
// acceptance until the result has been taken. For 1 <= n < MAX_ENTRIES a
// request first seeds the table (entry 0 = 1, entries 1..n = 0), then runs
// the update steps for part sizes s = 1..n, then drains the update pipeline,
// after which the result is offered. Zero or out-of-range inputs offer their
// result in the cycle straight after acceptance. The schedule is set by the
// single shared 32-bit adder and the table memory's one write port: each
// cycle performs one step table[m] += table[m - s], issued as two reads in
// one cycle and written back in the next. A step that reads a word written
// in the same cycle takes the value off the write bus. Sums wrap modulo
// 2^32; at the default depth p(127) still fits.
// ----------------------------------------------------------------------------
`include "integer_partition_count_macros.svh"

module integer_partition_count #(
    parameter int MAX_ENTRIES = ipc_pkg::MAX_ENTRIES_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    ipc_req_if.sink   request,
    ipc_rsp_if.source result
);
    import ipc_pkg::*;

    localparam int AW = $clog2(MAX_ENTRIES);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_INIT,
        ST_RUN,
        ST_DONE
    } state_t;

    state_t         state_reg, state_next;
    logic [AW-1:0]  n_reg, n_next;          // requested n
    logic [AW-1:0]  s_reg, s_next;          // current part size
    logic [AW-1:0]  m_reg, m_next;          // entry being issued / seeded
    logic           issue_reg, issue_next;  // steps still to issue
    logic           p_valid_reg, p_valid_next;
    logic [AW-1:0]  p_addr_reg, p_addr_next;
    logic           p_last_reg, p_last_next;
    logic           fwd_a_reg, fwd_a_next;
    logic           fwd_b_reg, fwd_b_next;
    count_t         fwd_data_reg, fwd_data_next;
    count_t         result_reg, result_next;

    logic           wr_en;
    logic [AW-1:0]  wr_addr;
    count_t         wr_data;
    logic [AW-1:0]  rd_addr_a;
    logic [AW-1:0]  rd_addr_b;
    count_t         rd_data_a;
    count_t         rd_data_b;
    count_t         op_a;
    count_t         op_b;
    count_t         sum;
    logic           accept;
    logic           trivial;

    ipc_table_ram #(
        .DEPTH (MAX_ENTRIES),
        .AW    (AW)
    ) u_table (
        .clk       (clk),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .rd_addr_a (rd_addr_a),
        .rd_addr_b (rd_addr_b),
        .rd_data_a (rd_data_a),
        .rd_data_b (rd_data_b)
    );

    assign request.ready          = (state_reg == ST_IDLE);
    assign result.valid           = (state_reg == ST_DONE);
    assign result.partition_count = result_reg;

    assign accept  = request.valid && request.ready;
    assign trivial = (request.number_in == '0)
                  || (32'(request.number_in) >= 32'(MAX_ENTRIES));

    // shared adder: table[m] (old) + table[m - s] (this pass)
    assign op_a = fwd_a_reg ? fwd_data_reg : rd_data_a;
    assign op_b = fwd_b_reg ? fwd_data_reg : rd_data_b;
    assign sum  = op_a + op_b;

    always_comb
    begin
        state_next    = state_reg;
        n_next        = n_reg;
        s_next        = s_reg;
        m_next        = m_reg;
        issue_next    = issue_reg;
        p_valid_next  = 1'b0;
        p_addr_next   = p_addr_reg;
        p_last_next   = p_last_reg;
        result_next   = result_reg;
        wr_en         = 1'b0;
        wr_addr       = '0;
        wr_data       = '0;
        rd_addr_a     = '0;
        rd_addr_b     = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (trivial)
                    begin
                        result_next = '0;
                        state_next  = ST_DONE;
                    end
                    else
                    begin
                        n_next     = request.number_in[AW-1:0];
                        m_next     = '0;
                        state_next = ST_INIT;
                    end
                end
            end

            ST_INIT:
            begin
                wr_en   = 1'b1;
                wr_addr = m_reg;
                wr_data = (m_reg == '0) ? COUNT_W'(1) : '0;
                if (m_reg == n_reg)
                begin
                    s_next     = AW'(1);
                    m_next     = AW'(1);
                    issue_next = 1'b1;
                    state_next = ST_RUN;
                end
                else
                begin
                    m_next = m_reg + AW'(1);
                end
            end

            ST_RUN:
            begin
                if (issue_reg)
                begin
                    rd_addr_a    = m_reg;
                    rd_addr_b    = m_reg - s_reg;
                    p_valid_next = 1'b1;
                    p_addr_next  = m_reg;
                    p_last_next  = (m_reg == n_reg) && (s_reg == n_reg);
                    if (m_reg == n_reg)
                    begin
                        if (s_reg == n_reg)
                        begin
                            issue_next = 1'b0;
                        end
                        else
                        begin
                            s_next = s_reg + AW'(1);
                            m_next = s_reg + AW'(1);
                        end
                    end
                    else
                    begin
                        m_next = m_reg + AW'(1);
                    end
                end

                if (p_valid_reg)
                begin
                    wr_en   = 1'b1;
                    wr_addr = p_addr_reg;
                    wr_data = sum;
                    if (p_last_reg)
                    begin
                        // last step writes table[n]: that is the answer
                        result_next = sum;
                        state_next  = ST_DONE;
                    end
                end
            end

            ST_DONE:
            begin
                if (result.ready)
                begin
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // bypass when a read hits the word being written on the same edge
    assign fwd_a_next    = wr_en && (wr_addr == rd_addr_a);
    assign fwd_b_next    = wr_en && (wr_addr == rd_addr_b);
    assign fwd_data_next = wr_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            n_reg        <= '0;
            s_reg        <= '0;
            m_reg        <= '0;
            issue_reg    <= 1'b0;
            p_valid_reg  <= 1'b0;
            p_addr_reg   <= '0;
            p_last_reg   <= 1'b0;
            fwd_a_reg    <= 1'b0;
            fwd_b_reg    <= 1'b0;
            fwd_data_reg <= '0;
            result_reg   <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            n_reg        <= n_next;
            s_reg        <= s_next;
            m_reg        <= m_next;
            issue_reg    <= issue_next;
            p_valid_reg  <= p_valid_next;
            p_addr_reg   <= p_addr_next;
            p_last_reg   <= p_last_next;
            fwd_a_reg    <= fwd_a_next;
            fwd_b_reg    <= fwd_b_next;
            fwd_data_reg <= fwd_data_next;
            result_reg   <= result_next;
        end
    end

    // Sequencer invariants
    `IPC_ASSERT_IMPLIES(a_issue_in_range, clk, rst_n,
        (state_reg == ST_RUN) && issue_reg, (s_reg <= m_reg) && (m_reg <= n_reg))
    `IPC_ASSERT_IMPLIES(a_write_in_range, clk, rst_n,
        p_valid_reg, (p_addr_reg <= n_reg) && (state_reg == ST_RUN))
    `IPC_ASSERT_NEXT(a_last_step_done, clk, rst_n,
        p_valid_reg && p_last_reg, (state_reg == ST_DONE) && !p_valid_reg)
    `IPC_ASSERT_NEXT(a_zero_gives_zero, clk, rst_n,
        accept && (request.number_in == '0),
        result.valid && (result.partition_count == '0))

endmodule
